FILE: rtl/core/fsp_pkg.sv
package fsp_pkg;

  // Default number of slots in the pool.
  localparam int NumSlotsDefault = 256;

  // Field widths fixed by the interface.
  localparam int AddrW  = 32;
  localparam int BytesW = 16;
  localparam int RunW   = 9;
  localparam int CfgIdxW = 2;

  // Reset values of the configuration registers.
  localparam logic [AddrW-1:0]  BaseReset   = '0;
  localparam logic [BytesW-1:0] BytesReset  = 16'd1;
  localparam logic [RunW-1:0]   CountReset  = 9'd256;

  // Iteration counts of the shared multiply/divide unit.
  localparam int MulSteps = BytesW;
  localparam int DivSteps = AddrW;
  localparam int StepW    = $clog2(DivSteps);

  typedef enum logic [CfgIdxW-1:0] {
    REG_BASE   = 2'd0,
    REG_SBYTES = 2'd1,
    REG_SCOUNT = 2'd2
  } reg_idx_e;

  typedef enum logic [2:0] {
    OP_ALLOC_ONE = 3'd0,
    OP_ALLOC_RUN = 3'd1,
    OP_FREE_ONE  = 3'd2,
    OP_FREE_RUN  = 3'd3,
    OP_CLEAR     = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_BADADDR = 2'd2,
    STATUS_BADRUN  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_SCAN,
    S_WRITE,
    S_MUL
  } state_e;

  typedef enum logic {
    MD_MUL,
    MD_DIV
  } md_mode_e;

  typedef struct packed {
    logic              start;
    md_mode_e          mode;
    logic [AddrW-1:0]  opa;
    logic [BytesW-1:0] opb;
  } md_req_t;

  typedef struct packed {
    logic              done;
    logic [AddrW-1:0]  result;
    logic [BytesW-1:0] rem;
  } md_rsp_t;

endpackage

FILE: rtl/core/fixed_slot_pool_allocator.sv
// Fixed-slot pool allocator with first-fit run search.
//
// A request transaction is accepted at a rising edge where start is high and busy is low.
// The opcode selects allocate one slot, allocate a run, free one slot, free a run or clear
// all. Exactly one result transaction follows: done_o is high for one cycle with status_o
// and slot_address_o valid. The receiver cannot stall, so the result is simply presented.
// Requests that fail the checks made at acceptance answer in the next cycle.
// Allocation streams the used bits of the pool through a memory with one read and one write
// port, one slot per cycle, then writes the run one slot per cycle and forms base plus
// size times index on a shared shift-and-add unit. Free operations first divide the offset
// by the slot size on the same unit; a free run then checks and rewrites n slots, one per
// cycle each. Clear all sweeps NUM_SLOTS entries, one per cycle.
// After reset the block runs the same sweep with busy high and gives no result for it;
// configuration writes are taken at any time but are meant for idle.
// Configuration registers: index 0 base address, 1 slot size in bytes, 2 slot count.
module fixed_slot_pool_allocator import fsp_pkg::*; #(
  parameter int NUM_SLOTS = NumSlotsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [AddrW-1:0]     cfg_wdata_i,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           opcode_i,
  input  logic [AddrW-1:0]     address_i,
  input  logic [RunW-1:0]      run_length_i,
  output logic                 done_o,
  output logic [1:0]           status_o,
  output logic [AddrW-1:0]     slot_address_o
);

  // Count width holds NUM_SLOTS itself; index width addresses the memory.
  localparam int CW = $clog2(NUM_SLOTS + 1);
  localparam int EW = (CW > RunW) ? CW : RunW;
  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Configuration registers.
  logic [AddrW-1:0]  base_q;
  logic [BytesW-1:0] sbytes_q;
  logic [RunW-1:0]   scount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= BaseReset;
      sbytes_q <= BytesReset;
      scount_q <= CountReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BASE:   base_q   <= cfg_wdata_i;
        REG_SBYTES: sbytes_q <= cfg_wdata_i[BytesW-1:0];
        REG_SCOUNT: scount_q <= cfg_wdata_i[RunW-1:0];
        default: ;
      endcase
    end
  end

  // Effective slot count: the smaller of the register and the pool size.
  logic [EW-1:0] scount_ext;
  logic [EW-1:0] cnt;
  assign scount_ext = EW'(scount_q);
  assign cnt = (scount_ext < EW'(NUM_SLOTS)) ? scount_ext : EW'(NUM_SLOTS);

  // Sequencer state.
  state_e            state_q, state_d;
  opcode_e           op_q, op_d;
  logic [EW-1:0]     n_q, n_d;
  logic [EW-1:0]     ptr_q, ptr_d;
  logic [EW-1:0]     end_q, end_d;
  logic [EW-1:0]     first_q, first_d;
  logic [EW-1:0]     run_q, run_d;
  logic              pend_q, pend_d;
  logic [EW-1:0]     pidx_q, pidx_d;
  logic              wval_q, wval_d;
  logic              report_q, report_d;
  logic              done_q, done_d;
  status_e           status_q, status_d;
  logic [AddrW-1:0]  saddr_q, saddr_d;

  md_req_t           md_req;
  md_rsp_t           md_rsp;

  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic              ram_wdata;
  logic [IW-1:0]     ram_raddr;
  logic              ram_rdata;

  logic [AddrW-1:0]  offset;
  logic [EW:0]       run_end;
  logic [EW-1:0]     idx;
  logic [EW-1:0]     found_first;
  logic              is_alloc;

  assign offset      = address_i - base_q;
  assign idx         = md_rsp.result[EW-1:0];
  assign run_end     = {1'b0, idx} + {1'b0, n_q};
  assign found_first = pidx_q + EW'(1) - n_q;
  assign is_alloc    = (op_q == OP_ALLOC_ONE) || (op_q == OP_ALLOC_RUN);

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    n_d      = n_q;
    ptr_d    = ptr_q;
    end_d    = end_q;
    first_d  = first_q;
    run_d    = run_q;
    pend_d   = 1'b0;
    pidx_d   = pidx_q;
    wval_d   = wval_q;
    report_d = report_q;
    done_d   = 1'b0;
    status_d = status_q;
    saddr_d  = '0;

    md_req.start = 1'b0;
    md_req.mode  = MD_DIV;
    md_req.opa   = offset;
    md_req.opb   = sbytes_q;

    ram_we    = 1'b0;
    ram_waddr = ptr_q[IW-1:0];
    ram_wdata = wval_q;
    ram_raddr = ptr_q[IW-1:0];

    case (state_q)
      S_CLEAR: begin
        // Sweep every entry to free, after reset or on clear all.
        ram_we    = 1'b1;
        ram_wdata = 1'b0;
        ptr_d     = ptr_q + EW'(1);
        if (ptr_q == EW'(NUM_SLOTS - 1)) begin
          state_d  = S_IDLE;
          report_d = 1'b0;
          if (report_q) begin
            done_d   = 1'b1;
            status_d = STATUS_OK;
          end
        end
      end

      S_IDLE: begin
        if (start) begin
          op_d  = opcode_e'(opcode_i);
          n_d   = ((opcode_i == OP_ALLOC_ONE) || (opcode_i == OP_FREE_ONE)) ?
                  EW'(1) : EW'(run_length_i);
          ptr_d = '0;
          end_d = cnt;
          run_d = '0;
          case (opcode_i)
            OP_ALLOC_ONE: begin
              if (cnt == '0) begin
                done_d   = 1'b1;
                status_d = STATUS_FULL;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_ALLOC_RUN: begin
              if (run_length_i == '0) begin
                done_d   = 1'b1;
                status_d = STATUS_BADRUN;
              end else if (EW'(run_length_i) > cnt) begin
                done_d   = 1'b1;
                status_d = STATUS_FULL;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_FREE_ONE, OP_FREE_RUN: begin
              if ((opcode_i == OP_FREE_RUN) && (run_length_i == '0)) begin
                done_d   = 1'b1;
                status_d = STATUS_BADRUN;
              end else if ((sbytes_q == '0) || (address_i < base_q)) begin
                done_d   = 1'b1;
                status_d = STATUS_BADADDR;
              end else begin
                md_req.start = 1'b1;
                state_d      = S_DIV;
              end
            end
            OP_CLEAR: begin
              report_d = 1'b1;
              state_d  = S_CLEAR;
            end
            default: begin
              done_d   = 1'b1;
              status_d = STATUS_BADRUN;
            end
          endcase
        end
      end

      S_DIV: begin
        if (md_rsp.done) begin
          if ((md_rsp.rem != '0) || (md_rsp.result >= AddrW'(cnt))) begin
            done_d   = 1'b1;
            status_d = STATUS_BADADDR;
            state_d  = S_IDLE;
          end else if (op_q == OP_FREE_ONE) begin
            first_d = idx;
            ptr_d   = idx;
            end_d   = idx + EW'(1);
            wval_d  = 1'b0;
            state_d = S_WRITE;
          end else if (run_end > {1'b0, cnt}) begin
            done_d   = 1'b1;
            status_d = STATUS_BADRUN;
            state_d  = S_IDLE;
          end else begin
            first_d = idx;
            ptr_d   = idx;
            end_d   = run_end[EW-1:0];
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue one read per cycle; the data of the previous read is checked now.
        if (ptr_q != end_q) begin
          pend_d = 1'b1;
          pidx_d = ptr_q;
          ptr_d  = ptr_q + EW'(1);
        end
        if (pend_q) begin
          if (is_alloc) begin
            if (ram_rdata) begin
              run_d = '0;
            end else begin
              run_d = run_q + EW'(1);
              if (run_q + EW'(1) == n_q) begin
                // Lowest run of free slots found: mark it used.
                pend_d  = 1'b0;
                first_d = found_first;
                ptr_d   = found_first;
                end_d   = pidx_q + EW'(1);
                wval_d  = 1'b1;
                state_d = S_WRITE;
              end
            end
          end else if (!ram_rdata) begin
            // A free run must cover only used slots.
            pend_d   = 1'b0;
            done_d   = 1'b1;
            status_d = STATUS_BADRUN;
            state_d  = S_IDLE;
          end
        end else if (ptr_q == end_q) begin
          if (is_alloc) begin
            done_d   = 1'b1;
            status_d = STATUS_FULL;
            state_d  = S_IDLE;
          end else begin
            ptr_d   = first_q;
            wval_d  = 1'b0;
            state_d = S_WRITE;
          end
        end
      end

      S_WRITE: begin
        ram_we = 1'b1;
        ptr_d  = ptr_q + EW'(1);
        if (ptr_q + EW'(1) == end_q) begin
          if (is_alloc) begin
            md_req.start = 1'b1;
            md_req.mode  = MD_MUL;
            md_req.opa   = AddrW'(first_q);
            state_d      = S_MUL;
          end else begin
            done_d   = 1'b1;
            status_d = STATUS_OK;
            state_d  = S_IDLE;
          end
        end
      end

      S_MUL: begin
        if (md_rsp.done) begin
          done_d   = 1'b1;
          status_d = STATUS_OK;
          saddr_d  = base_q + md_rsp.result;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      ptr_q    <= '0;
      pend_q   <= 1'b0;
      report_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      pend_q   <= pend_d;
      report_q <= report_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    n_q      <= n_d;
    end_q    <= end_d;
    first_q  <= first_d;
    run_q    <= run_d;
    pidx_q   <= pidx_d;
    wval_q   <= wval_d;
    status_q <= status_d;
    saddr_q  <= saddr_d;
  end

  fsp_ram #(
    .WIDTH (1),
    .DEPTH (NUM_SLOTS)
  ) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  fsp_muldiv u_muldiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (md_req),
    .rsp_o  (md_rsp)
  );

  assign busy           = (state_q != S_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign slot_address_o = saddr_q;

endmodule

FILE: rtl/core/fsp_ram.sv
module fsp_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/fsp_muldiv.sv
module fsp_muldiv import fsp_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  md_req_t req_i,
  output md_rsp_t rsp_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [StepW-1:0]  cnt_q, cnt_d;
  md_mode_e          mode_q, mode_d;
  logic [AddrW-1:0]  acc_q, acc_d;
  logic [AddrW-1:0]  sh_q, sh_d;
  logic [BytesW-1:0] rem_q, rem_d;
  logic [BytesW-1:0] b_q, b_d;
  logic [BytesW:0]   shifted;
  logic [BytesW:0]   sub;
  logic              ge;

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    mode_d  = mode_q;
    acc_d   = acc_q;
    sh_d    = sh_q;
    rem_d   = rem_q;
    b_d     = b_q;
    shifted = {rem_q, sh_q[AddrW-1]};
    ge      = (shifted >= {1'b0, b_q});
    sub     = shifted - {1'b0, b_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      mode_d = req_i.mode;
      acc_d  = '0;
      rem_d  = '0;
      sh_d   = req_i.opa;
      b_d    = req_i.opb;
      cnt_d  = (req_i.mode == MD_MUL) ? StepW'(MulSteps - 1) : StepW'(DivSteps - 1);
    end else if (busy_q) begin
      if (mode_q == MD_MUL) begin
        // Shift-and-add: one multiplier bit per cycle.
        if (b_q[0]) begin
          acc_d = acc_q + sh_q;
        end
        sh_d = {sh_q[AddrW-2:0], 1'b0};
        b_d  = {1'b0, b_q[BytesW-1:1]};
      end else begin
        // Restoring division: one quotient bit per cycle.
        rem_d = ge ? sub[BytesW-1:0] : shifted[BytesW-1:0];
        sh_d  = {sh_q[AddrW-2:0], ge};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    mode_q <= mode_d;
    acc_q  <= acc_d;
    sh_q   <= sh_d;
    rem_q  <= rem_d;
    b_q    <= b_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = (mode_q == MD_MUL) ? acc_q : sh_q;
  assign rsp_o.rem    = rem_q;

endmodule

FILE: rtl/core/fsp_checker.sv
module fsp_checker import fsp_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [CfgIdxW-1:0] cfg_idx_i,
  input logic [AddrW-1:0]   cfg_wdata_i,
  input logic               start,
  input logic               busy,
  input logic [2:0]         opcode_i,
  input logic [AddrW-1:0]   address_i,
  input logic [RunW-1:0]    run_length_i,
  input logic               done_o,
  input logic [1:0]         status_o,
  input logic [AddrW-1:0]   slot_address_o
);

  // An accepted transaction either keeps the block busy or answers at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || done_o)
    else $error("accepted transaction neither busy nor answered");

  // A result is shown only once the block is ready again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  // Failed requests return a zero address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != STATUS_OK) |-> slot_address_o == '0)
    else $error("nonzero address on failed request");

  // A result shown after an idle cycle answers a transaction accepted in that cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !$past(busy) |-> $past(start))
    else $error("result without an accepted transaction");

endmodule

bind fixed_slot_pool_allocator fsp_checker u_fsp_checker (.*);

FILE: tb/sv/tb.sv
module tb;
  import fsp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Pool size of the instance under test.
  localparam int NumSlots = NumSlotsDefault;

  // Opcode values outside the decoded set; the block must reject them.
  localparam logic [2:0] OpUnusedFirst = 3'd5;
  localparam logic [2:0] OpUnusedLast  = 3'd7;

  // Random transactions per register setting, and the number of settings.
  localparam int ItemsPerPhase = 135;
  localparam int PhaseCount    = 8;

  // After the last result the bench keeps watching for stray strobes, long enough
  // to cover a full scan plus the address multiply.
  localparam int TailCycles = 300;

  // The slowest legal transaction is a 256-slot free run; with about 1100
  // transactions and sender gaps this bound leaves a wide margin.
  localparam int CycleLimit = 3_000_000;

  // One expected result transaction.
  typedef struct packed {
    status_e     st;
    logic [31:0] sa;
  } pool_answer_t;

  // One row of the directed table: either a register write or a request. Rows
  // with typed set carry the expected answer as written in the table.
  typedef struct {
    bit          is_write;
    reg_idx_e    reg_sel;
    logic [31:0] wdata;
    logic [2:0]  op;
    logic [31:0] addr;
    logic [8:0]  len;
    bit          typed;
    status_e     st;
    logic [31:0] sa;
  } step_row_t;

  // Clock, reset and every block input start at a known value.
  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i     = '0;
  logic [AddrW-1:0]  cfg_wdata_i    = '0;
  logic              start          = 1'b0;
  logic              busy;
  logic [2:0]        opcode_i       = '0;
  logic [AddrW-1:0]  address_i      = '0;
  logic [RunW-1:0]   run_length_i   = '0;
  logic              done_o;
  logic [1:0]        status_o;
  logic [AddrW-1:0]  slot_address_o;

  // Shadow of the block: used bit per slot and the three registers.
  logic [NumSlots-1:0] pool_used   = '0;
  logic [AddrW-1:0]    pool_base   = BaseReset;
  logic [BytesW-1:0]   pool_sbytes = BytesReset;
  logic [RunW-1:0]     pool_scount = CountReset;

  // Answers predicted for accepted requests, oldest first.
  pool_answer_t awaited_answers[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int gap_ceiling    = 9;

  fixed_slot_pool_allocator #(
    .NUM_SLOTS(NumSlots)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .address_i     (address_i),
    .run_length_i  (run_length_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .slot_address_o(slot_address_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow pool arithmetic.
  // ---------------------------------------------------------------------------

  // Slots that take part in allocation and freeing; a larger count saturates at
  // the pool size.
  function automatic int usable_slots();
    return (int'(pool_scount) < NumSlots) ? int'(pool_scount) : NumSlots;
  endfunction

  // Byte address of a slot; wraps modulo 2^32 like the hardware adder.
  function automatic logic [31:0] slot_addr(input int idx);
    return pool_base + 32'(pool_sbytes) * 32'(idx);
  endfunction

  // Turns a free address into a slot index. It fails for a zero slot size, an
  // address below the base, an address off a slot boundary, or an index past
  // the usable range.
  function automatic bit slot_index_of(input logic [31:0] a, output int idx);
    logic [31:0] off;
    logic [31:0] q;
    idx = 0;
    if (pool_sbytes == '0 || a < pool_base) return 1'b0;
    off = a - pool_base;
    if (off % {16'h0, pool_sbytes} != 32'h0) return 1'b0;
    q = off / {16'h0, pool_sbytes};
    if (q >= 32'(usable_slots())) return 1'b0;
    idx = int'(q);
    return 1'b1;
  endfunction

  // Applies one request to the shadow pool and works out the answer the block
  // owes for it.
  task automatic compute_pool_answer(input logic [2:0] op, input logic [31:0] addr,
                                     input logic [8:0] len, output status_e st,
                                     output logic [31:0] sa);
    int cnt;
    int n;
    int idx;
    bit fits;
    cnt = usable_slots();
    n   = int'(len);
    st  = STATUS_OK;
    sa  = '0;
    case (op)
      OP_ALLOC_ONE: begin
        st = STATUS_FULL;
        for (int i = 0; i < cnt; i++) begin
          if (!pool_used[i]) begin
            pool_used[i] = 1'b1;
            st = STATUS_OK;
            sa = slot_addr(i);
            break;
          end
        end
      end
      OP_ALLOC_RUN: begin
        if (n == 0) begin
          st = STATUS_BADRUN;
        end else begin
          st = STATUS_FULL;
          // First fit: the lowest start whose whole run is free, up to and
          // including the last position that still fits.
          for (int i = 0; i + n <= cnt; i++) begin
            fits = 1'b1;
            for (int j = 0; j < n; j++) begin
              if (pool_used[i+j]) begin
                fits = 1'b0;
                break;
              end
            end
            if (fits) begin
              for (int j = 0; j < n; j++) pool_used[i+j] = 1'b1;
              st = STATUS_OK;
              sa = slot_addr(i);
              break;
            end
          end
        end
      end
      OP_FREE_ONE: begin
        // Freeing a slot that is already free is still a success.
        if (!slot_index_of(addr, idx)) st = STATUS_BADADDR;
        else pool_used[idx] = 1'b0;
      end
      OP_FREE_RUN: begin
        if (n == 0) begin
          st = STATUS_BADRUN;
        end else if (!slot_index_of(addr, idx)) begin
          st = STATUS_BADADDR;
        end else if (idx + n > cnt) begin
          st = STATUS_BADRUN;
        end else begin
          // The run must be wholly allocated; otherwise nothing changes.
          for (int j = 0; j < n; j++) begin
            if (!pool_used[idx+j]) st = STATUS_BADRUN;
          end
          if (st == STATUS_OK) begin
            for (int j = 0; j < n; j++) pool_used[idx+j] = 1'b0;
          end
        end
      end
      OP_CLEAR: begin
        // Clear all reaches every slot, also those beyond a reduced count.
        pool_used = '0;
      end
      default: begin
        st = STATUS_BADRUN;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------

  // Drops start and waits until every predicted answer has arrived and the
  // block reports idle. This is also the pause that lets the pipeline drain.
  task automatic wait_idle();
    start <= 1'b0;
    while (awaited_answers.size() != 0 || busy !== 1'b0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes one register while the block is idle and mirrors it in the shadow.
  task automatic write_reg(input reg_idx_e r, input logic [31:0] d);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= r;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    case (r)
      REG_BASE:   pool_base   = d;
      REG_SBYTES: pool_sbytes = d[BytesW-1:0];
      REG_SCOUNT: pool_scount = d[RunW-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
  endtask

  // Presents one request transaction after a random gap and holds it until the
  // block takes it. A zero gap keeps start high straight into the next request,
  // so back-to-back transactions get exercised as well.
  task automatic send_request(input logic [2:0] op, input logic [31:0] addr,
                              input logic [8:0] len, input bit typed,
                              input status_e t_st, input logic [31:0] t_sa);
    int gap;
    status_e st;
    logic [31:0] sa;
    gap = (gap_ceiling == 0) ? 0 : $urandom_range(0, gap_ceiling);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    opcode_i     <= op;
    address_i    <= addr;
    run_length_i <= len;
    do @(posedge clk_i); while (!(start === 1'b1 && busy === 1'b0));
    compute_pool_answer(op, addr, len, st, sa);
    if (typed) awaited_answers.push_back('{t_st, t_sa});
    else awaited_answers.push_back('{st, sa});
  endtask

  // Start of a random run: mostly a slot that is in use, so that frees and free
  // runs get past the checks; 0 when nothing is usable.
  function automatic int pick_used_slot();
    int cnt;
    int first;
    int i;
    cnt = usable_slots();
    if (cnt == 0) return 0;
    first = $urandom_range(0, cnt - 1);
    for (int k = 0; k < cnt; k++) begin
      i = (first + k) % cnt;
      if (pool_used[i]) return i;
    end
    return first;
  endfunction

  // One random request: allocations and frees, mostly of live slots and modest runs,
  // with a share of misaligned, out-of-range, below-base and raw addresses,
  // zero and oversize run lengths, clears and undecoded opcodes.
  task automatic issue_random_request();
    int pick;
    int cnt;
    int idx;
    logic [2:0]  op;
    logic [31:0] addr;
    logic [8:0]  len;
    cnt  = usable_slots();
    pick = $urandom_range(0, 99);
    if (pick < 30) op = OP_ALLOC_ONE;
    else if (pick < 50) op = OP_ALLOC_RUN;
    else if (pick < 75) op = OP_FREE_ONE;
    else if (pick < 92) op = OP_FREE_RUN;
    else if (pick < 95) op = OP_CLEAR;
    else op = 3'($urandom_range(OpUnusedFirst, OpUnusedLast));

    pick = $urandom_range(0, 19);
    if (pick == 0) len = '0;
    else if (pick == 1) len = 9'($urandom_range(0, NumSlots));
    else if (pick == 2) len = 9'(cnt);
    else if (pick == 3) len = 9'((cnt < NumSlots) ? cnt + 1 : $urandom_range(0, NumSlots));
    else len = 9'($urandom_range(1, 6));

    pick = $urandom_range(0, 19);
    if (pick < 13) begin
      addr = slot_addr(pick_used_slot());
    end else if (pick < 15) begin
      addr = slot_addr($urandom_range(0, cnt));
    end else if (pick < 17) begin
      idx  = $urandom_range(0, (cnt > 0) ? cnt - 1 : 0);
      addr = slot_addr(idx) +
             32'($urandom_range(1, (pool_sbytes > 1) ? int'(pool_sbytes) - 1 : 1));
    end else if (pick == 17) begin
      addr = pool_base - 32'($urandom_range(1, 64));
    end else begin
      addr = $urandom();
    end
    send_request(op, addr, len, 1'b0, STATUS_OK, '0);
  endtask

  // Directed table builders.
  function automatic step_row_t cfg_row(input reg_idx_e r, input logic [31:0] d);
    step_row_t row;
    row         = '{default: '0, reg_sel: REG_BASE, st: STATUS_OK};
    row.is_write = 1'b1;
    row.reg_sel  = r;
    row.wdata    = d;
    return row;
  endfunction

  function automatic step_row_t req_row(input logic [2:0] op, input logic [31:0] addr,
                                        input logic [8:0] len, input bit typed,
                                        input status_e st, input logic [31:0] sa);
    step_row_t row;
    row       = '{default: '0, reg_sel: REG_BASE, st: STATUS_OK};
    row.op    = op;
    row.addr  = addr;
    row.len   = len;
    row.typed = typed;
    row.st    = st;
    row.sa    = sa;
    return row;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking. The receiver cannot stall, so every strobe is one result
  // transaction and is matched against the oldest prediction.
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("[%0t] mismatch on %s: expected 0x%08h, got 0x%08h", $time, what, want, got);
  endtask

  always @(posedge clk_i) begin : result_check
    pool_answer_t head;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (awaited_answers.size() == 0) begin
        report_mismatch("result with nothing awaited, status", '0, 32'(status_o));
      end else begin
        head = awaited_answers.pop_front();
        if (status_o !== head.st) report_mismatch("status", 32'(head.st), 32'(status_o));
        if (slot_address_o !== head.sa) report_mismatch("slot address", head.sa, slot_address_o);
      end
    end
  end

  // Watchdog: a missing result or a block stuck busy ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    step_row_t steps[$];
    logic [31:0] new_base;
    logic [31:0] new_sbytes;
    logic [31:0] new_scount;

    // Reset defaults: base 0, one byte per slot, 256 slots, empty pool.
    steps.push_back(req_row(OP_ALLOC_ONE, '0, '0, 1'b1, STATUS_OK, 32'h0));
    steps.push_back(req_row(OP_FREE_ONE, 32'h0, '0, 1'b1, STATUS_OK, 32'h0));
    steps.push_back(req_row(OpUnusedLast, 32'hFFFF_FFFF, 9'h1FF, 1'b1, STATUS_BADRUN, 32'h0));
    steps.push_back(req_row(OP_ALLOC_RUN, '0, 9'd0, 1'b1, STATUS_BADRUN, 32'h0));
    steps.push_back(req_row(OP_ALLOC_RUN, '0, 9'd256, 1'b1, STATUS_OK, 32'h0));
    steps.push_back(req_row(OP_ALLOC_ONE, '0, '0, 1'b1, STATUS_FULL, 32'h0));
    steps.push_back(req_row(OP_FREE_RUN, 32'h0, 9'd256, 1'b1, STATUS_OK, 32'h0));
    steps.push_back(req_row(OP_ALLOC_RUN, '0, 9'd257, 1'b1, STATUS_FULL, 32'h0));
    steps.push_back(req_row(OP_FREE_RUN, 32'h0, 9'd0, 1'b1, STATUS_BADRUN, 32'h0));
    steps.push_back(req_row(OP_FREE_ONE, 32'hFFFF_FFFF, '0, 1'b1, STATUS_BADADDR, 32'h0));
    // Eight 16-byte slots at 0x1000.
    steps.push_back(cfg_row(REG_BASE, 32'h0000_1000));
    steps.push_back(cfg_row(REG_SBYTES, 32'd16));
    steps.push_back(cfg_row(REG_SCOUNT, 32'd8));
    steps.push_back(req_row(OP_FREE_ONE, 32'h0000_0FFF, '0, 1'b1, STATUS_BADADDR, 32'h0));
    steps.push_back(req_row(OP_FREE_ONE, 32'h0000_1008, '0, 1'b1, STATUS_BADADDR, 32'h0));
    steps.push_back(req_row(OP_ALLOC_RUN, '0, 9'd8, 1'b1, STATUS_OK, 32'h0000_1000));
    steps.push_back(req_row(OP_FREE_ONE, 32'h0000_1000, '0, 1'b1, STATUS_OK, 32'h0));
    steps.push_back(req_row(OP_FREE_ONE, 32'h0000_1000, '0, 1'b1, STATUS_OK, 32'h0));
    steps.push_back(req_row(OP_FREE_RUN, 32'h0000_1000, 9'd2, 1'b1, STATUS_BADRUN, 32'h0));
    steps.push_back(req_row(OP_FREE_RUN, 32'h0000_1070, 9'd2, 1'b1, STATUS_BADRUN, 32'h0));
    steps.push_back(req_row(OP_FREE_RUN, 32'h0000_1060, 9'd2, 1'b1, STATUS_OK, 32'h0));
    // Only the last two slots form a run of two: the search must try the end.
    steps.push_back(req_row(OP_ALLOC_RUN, '0, 9'd2, 1'b1, STATUS_OK, 32'h0000_1060));
    // Shrunk pool: slots 4..7 keep their bits but are out of reach.
    steps.push_back(cfg_row(REG_SCOUNT, 32'd4));
    steps.push_back(req_row(OP_ALLOC_ONE, '0, '0, 1'b1, STATUS_OK, 32'h0000_1000));
    steps.push_back(req_row(OP_FREE_ONE, 32'h0000_1040, '0, 1'b1, STATUS_BADADDR, 32'h0));
    steps.push_back(req_row(OP_CLEAR, '0, '0, 1'b1, STATUS_OK, 32'h0));
    steps.push_back(cfg_row(REG_SCOUNT, 32'd0));
    steps.push_back(req_row(OP_ALLOC_ONE, '0, '0, 1'b1, STATUS_FULL, 32'h0));
    // Zero slot size: every slot sits at the base and nothing can be freed.
    steps.push_back(cfg_row(REG_BASE, 32'hFFFF_FFF0));
    steps.push_back(cfg_row(REG_SBYTES, 32'd0));
    steps.push_back(cfg_row(REG_SCOUNT, 32'd256));
    steps.push_back(req_row(OP_ALLOC_ONE, '0, '0, 1'b1, STATUS_OK, 32'hFFFF_FFF0));
    steps.push_back(req_row(OP_ALLOC_RUN, '0, 9'd3, 1'b1, STATUS_OK, 32'hFFFF_FFF0));
    steps.push_back(req_row(OP_FREE_ONE, 32'hFFFF_FFF0, '0, 1'b1, STATUS_BADADDR, 32'h0));
    // Largest slot size near the top of the address space: addresses wrap.
    steps.push_back(cfg_row(REG_SBYTES, 32'h0000_FFFF));
    steps.push_back(req_row(OP_ALLOC_ONE, '0, '0, 1'b0, STATUS_OK, 32'h0));
    steps.push_back(req_row(OP_FREE_ONE, 32'hFFFF_FFF0, '0, 1'b0, STATUS_OK, 32'h0));
    steps.push_back(req_row(OP_FREE_RUN, 32'h0000_FFEF, 9'd3, 1'b0, STATUS_OK, 32'h0));

    // Reset once; the block then sweeps its memory with busy high.
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    gap_ceiling = 9;
    foreach (steps[k]) begin
      if (steps[k].is_write) write_reg(steps[k].reg_sel, steps[k].wdata);
      else send_request(steps[k].op, steps[k].addr, steps[k].len, steps[k].typed,
                        steps[k].st, steps[k].sa);
    end

    // Random phases, each under its own register setting, extremes included.
    for (int phase = 0; phase < PhaseCount; phase++) begin
      case (phase)
        0: begin new_base = $urandom(); new_sbytes = 1; new_scount = 256; end
        1: begin new_base = 0; new_sbytes = 32'h0000_FFFF; new_scount = 256; end
        2: begin new_base = 32'hFFFF_FFFF; new_sbytes = 4; new_scount = 16; end
        3: begin new_base = $urandom(); new_sbytes = 0; new_scount = 5; end
        4: begin
          new_base   = $urandom();
          new_sbytes = $urandom_range(1, 64);
          new_scount = $urandom_range(1, NumSlots);
        end
        5: begin new_base = 0; new_sbytes = 1; new_scount = 1; end
        6: begin new_base = $urandom(); new_sbytes = $urandom_range(1, 65535); new_scount = 0; end
        default: begin new_base = $urandom_range(0, 1000); new_sbytes = 8; new_scount = 256; end
      endcase
      write_reg(REG_BASE, new_base);
      write_reg(REG_SBYTES, new_sbytes);
      write_reg(REG_SCOUNT, new_scount);

      for (int item = 0; item < ItemsPerPhase; item++) begin
        // Every 32 items the sender picks anew between stretches with and without gaps.
        if (item % 32 == 0) gap_ceiling = ($urandom_range(0, 2) == 0) ? 0 : 9;
        // Now and then the sender holds off until the block has fully drained.
        if ($urandom_range(0, 99) == 0) wait_idle();
        issue_random_request();
      end
    end

    wait_idle();
    repeat (TailCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
